// File: rtl/core/ifr_pkg.sv
// Shared types and constants of the idle-delimited frame receiver.
// Used by ifr_ctrl, ifr_datapath, the top level and the port checker.
// No dependencies.
package ifr_pkg;

   // Frame store depth default and fixed frame layout
   localparam int BUFFER_DEPTH_DEF = 64;
   localparam int MIN_FRAME        = 3;
   localparam int LIMIT_CAP        = 61;

   // Field widths
   localparam int OP_W     = 2;
   localparam int BYTE_W   = 8;
   localparam int LIMIT_W  = 6;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 6;
   localparam int CSR_W    = 8;
   localparam int CSR_IDX_W = 1;

   // Operation codes
   localparam logic [OP_W-1:0] OP_BYTE    = 2'd0;
   localparam logic [OP_W-1:0] OP_IDLE    = 2'd1;
   localparam logic [OP_W-1:0] OP_CONSUME = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_NO_FRAME  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_VALID     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd2;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] REG_HEADER = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT  = 1'd1;
   localparam logic [BYTE_W-1:0]    HEADER_RST = 8'd170;
   localparam logic [LIMIT_W-1:0]   LIMIT_RST  = 6'd55;

   // Frame store read address selects
   localparam logic [1:0] RA_HDR = 2'd0;
   localparam logic [1:0] RA_CMD = 2'd1;
   localparam logic [1:0] RA_LEN = 2'd2;
   localparam logic [1:0] RA_PAY = 2'd3;

   // Result kinds loaded into the output register
   localparam logic [1:0] OK_NO_FRAME  = 2'd0;
   localparam logic [1:0] OK_BAD       = 2'd1;
   localparam logic [1:0] OK_EMPTY     = 2'd2;
   localparam logic [1:0] OK_BYTE      = 2'd3;

   typedef struct packed {
      logic       byte_wr;
      logic       line_idle;
      logic       release_frame;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       cap_hdr;
      logic       cap_cmd;
      logic       cap_len;
      logic       idx_clr;
      logic       idx_inc;
      logic       out_load;
      logic [1:0] out_kind;
   } ifr_cmd_type;

   typedef struct packed {
      logic held;
      logic frame_ok;
      logic len_zero;
      logic idx_last;
      logic out_busy;
      logic out_free;
   } ifr_status_type;

endpackage

// File: rtl/core/ifr_datapath.sv
// Datapath of the frame receiver: frame store, fill and held counters,
// configuration registers, header checks and the result register.
// Depends on ifr_pkg.
module ifr_datapath #(
   parameter int BUFFER_DEPTH = ifr_pkg::BUFFER_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ifr_pkg::ifr_cmd_type              cmd,
   output ifr_pkg::ifr_status_type           sts,
   input  logic [ifr_pkg::BYTE_W-1:0]        req_rx_byte,
   input  logic                              csr_write_en,
   input  logic [ifr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ifr_pkg::CSR_W-1:0]         csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ifr_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ifr_pkg::BYTE_W-1:0]        rsp_command,
   output logic [ifr_pkg::LEN_W-1:0]         rsp_payload_len,
   output logic                              rsp_has_byte,
   output logic [ifr_pkg::BYTE_W-1:0]        rsp_payload_byte,
   output logic                              rsp_last
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CW = $clog2(BUFFER_DEPTH + 1);

   logic [ifr_pkg::BYTE_W-1:0] store [BUFFER_DEPTH];

   logic [CW-1:0]                   fill_ff, fill_in;
   logic [CW-1:0]                   held_len_ff, held_len_in;
   logic                            held_ff, held_in;
   logic [ifr_pkg::BYTE_W-1:0]      header_ff;
   logic [ifr_pkg::LIMIT_W-1:0]     limit_ff;
   logic [ifr_pkg::BYTE_W-1:0]      rdata_ff;
   logic                            hdr_ok_ff;
   logic [ifr_pkg::BYTE_W-1:0]      cmd_ff;
   logic [ifr_pkg::BYTE_W-1:0]      len_ff;
   logic [ifr_pkg::LEN_W-1:0]       idx_ff, idx_in;
   logic                            out_valid_ff, out_valid_in;
   logic [ifr_pkg::STATUS_W-1:0]    out_status_ff;
   logic [ifr_pkg::BYTE_W-1:0]      out_command_ff;
   logic [ifr_pkg::LEN_W-1:0]       out_len_ff;
   logic                            out_has_byte_ff;
   logic [ifr_pkg::BYTE_W-1:0]      out_byte_ff;
   logic                            out_last_ff;

   logic                            store_we;
   logic [AW-1:0]                   rd_addr;
   logic [8:0]                      pay_sum;
   logic [ifr_pkg::LIMIT_W-1:0]     limit_eff;
   logic [9:0]                      need_len;
   logic                            idx_last;

   // Bytes are dropped while a frame is held or once the store is full
   assign store_we = cmd.byte_wr && !held_ff && (fill_ff < CW'(BUFFER_DEPTH));

   always_ff @(posedge clock) begin
      if (store_we) begin
         store[fill_ff[AW-1:0]] <= req_rx_byte;
      end
   end

   assign pay_sum = 9'(ifr_pkg::MIN_FRAME) + {3'b000, idx_ff};

   always_comb begin
      unique case (cmd.rd_sel)
         ifr_pkg::RA_HDR: rd_addr = AW'(0);
         ifr_pkg::RA_CMD: rd_addr = AW'(1);
         ifr_pkg::RA_LEN: rd_addr = AW'(2);
         ifr_pkg::RA_PAY: rd_addr = pay_sum[AW-1:0];
         default:         rd_addr = AW'(0);
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= store[rd_addr];
      end
   end

   always_comb begin
      fill_in     = fill_ff;
      held_len_in = held_len_ff;
      held_in     = held_ff;
      if (store_we) begin
         fill_in = fill_ff + CW'(1);
      end
      if (cmd.line_idle && (fill_ff != '0)) begin
         if (!held_ff) begin
            held_len_in = fill_ff;
            held_in     = 1'b1;
         end
         fill_in = '0;
      end
      if (cmd.release_frame) begin
         held_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         held_len_ff <= '0;
         held_ff     <= 1'b0;
         header_ff   <= ifr_pkg::HEADER_RST;
         limit_ff    <= ifr_pkg::LIMIT_RST;
      end else begin
         fill_ff     <= fill_in;
         held_len_ff <= held_len_in;
         held_ff     <= held_in;
         if (csr_write_en && (csr_index == ifr_pkg::REG_HEADER)) begin
            header_ff <= csr_wdata;
         end
         if (csr_write_en && (csr_index == ifr_pkg::REG_LIMIT)) begin
            limit_ff <= csr_wdata[ifr_pkg::LIMIT_W-1:0];
         end
      end
   end

   // Header fields captured from the store one read at a time
   always_ff @(posedge clock) begin
      if (cmd.cap_hdr) begin
         hdr_ok_ff <= (rdata_ff == header_ff);
      end
      if (cmd.cap_cmd) begin
         cmd_ff <= rdata_ff;
      end
      if (cmd.cap_len) begin
         len_ff <= rdata_ff;
      end
   end

   assign limit_eff = (limit_ff > ifr_pkg::LIMIT_W'(ifr_pkg::LIMIT_CAP))
                    ? ifr_pkg::LIMIT_W'(ifr_pkg::LIMIT_CAP) : limit_ff;
   assign need_len  = {2'b00, len_ff} + 10'(ifr_pkg::MIN_FRAME);
   assign idx_last  = ({2'b00, idx_ff} + 8'd1) == len_ff;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + ifr_pkg::LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // Result register: a load takes priority over the handoff of the old item
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         unique case (cmd.out_kind)
            ifr_pkg::OK_NO_FRAME: begin
               out_status_ff   <= ifr_pkg::ST_NO_FRAME;
               out_command_ff  <= '0;
               out_len_ff      <= '0;
               out_has_byte_ff <= 1'b0;
               out_byte_ff     <= '0;
               out_last_ff     <= 1'b1;
            end
            ifr_pkg::OK_BAD: begin
               out_status_ff   <= ifr_pkg::ST_MALFORMED;
               out_command_ff  <= '0;
               out_len_ff      <= '0;
               out_has_byte_ff <= 1'b0;
               out_byte_ff     <= '0;
               out_last_ff     <= 1'b1;
            end
            ifr_pkg::OK_EMPTY: begin
               out_status_ff   <= ifr_pkg::ST_VALID;
               out_command_ff  <= cmd_ff;
               out_len_ff      <= '0;
               out_has_byte_ff <= 1'b0;
               out_byte_ff     <= '0;
               out_last_ff     <= 1'b1;
            end
            ifr_pkg::OK_BYTE: begin
               out_status_ff   <= ifr_pkg::ST_VALID;
               out_command_ff  <= cmd_ff;
               out_len_ff      <= len_ff[ifr_pkg::LEN_W-1:0];
               out_has_byte_ff <= 1'b1;
               out_byte_ff     <= rdata_ff;
               out_last_ff     <= idx_last;
            end
            default: begin
               out_status_ff   <= ifr_pkg::ST_NO_FRAME;
               out_command_ff  <= '0;
               out_len_ff      <= '0;
               out_has_byte_ff <= 1'b0;
               out_byte_ff     <= '0;
               out_last_ff     <= 1'b1;
            end
         endcase
      end
   end

   assign sts.held     = held_ff;
   assign sts.frame_ok = (held_len_ff >= CW'(ifr_pkg::MIN_FRAME)) && hdr_ok_ff
                      && (len_ff <= {2'b00, limit_eff})
                      && (10'(held_len_ff) >= need_len);
   assign sts.len_zero = (len_ff == '0);
   assign sts.idx_last = idx_last;
   assign sts.out_busy = out_valid_ff;
   assign sts.out_free = !out_valid_ff || rsp_ready;

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_command      = out_command_ff;
   assign rsp_payload_len  = out_len_ff;
   assign rsp_has_byte     = out_has_byte_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_last         = out_last_ff;

endmodule

// File: rtl/core/ifr_ctrl.sv
// Controller of the frame receiver: accepts items, sequences the header
// reads, the frame check and the payload readout.
// Depends on ifr_pkg.
module ifr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ifr_pkg::OP_W-1:0]      req_operation,
   input  ifr_pkg::ifr_status_type       sts,
   output ifr_pkg::ifr_cmd_type          cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_A0   = 3'd1;
   localparam logic [2:0] S_A1   = 3'd2;
   localparam logic [2:0] S_A2   = 3'd3;
   localparam logic [2:0] S_CHK  = 3'd4;
   localparam logic [2:0] S_PRD  = 3'd5;
   localparam logic [2:0] S_PWR  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       accept;

   // Hold a consume request while an earlier result still waits
   assign req_ready = (state_ff == S_IDLE)
                   && !((req_operation == ifr_pkg::OP_CONSUME) && sts.out_busy);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  ifr_pkg::OP_BYTE: cmd.byte_wr   = 1'b1;
                  ifr_pkg::OP_IDLE: cmd.line_idle = 1'b1;
                  ifr_pkg::OP_CONSUME: begin
                     if (sts.held) begin
                        cmd.release_frame = 1'b1;
                        cmd.rd_en         = 1'b1;
                        cmd.rd_sel        = ifr_pkg::RA_HDR;
                        state_in          = S_A0;
                     end else begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = ifr_pkg::OK_NO_FRAME;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_A0: begin
            cmd.cap_hdr = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = ifr_pkg::RA_CMD;
            state_in    = S_A1;
         end
         S_A1: begin
            cmd.cap_cmd = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = ifr_pkg::RA_LEN;
            state_in    = S_A2;
         end
         S_A2: begin
            cmd.cap_len = 1'b1;
            state_in    = S_CHK;
         end
         S_CHK: begin
            if (sts.out_free) begin
               priority if (!sts.frame_ok) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = ifr_pkg::OK_BAD;
                  state_in     = S_IDLE;
               end else if (sts.len_zero) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = ifr_pkg::OK_EMPTY;
                  state_in     = S_IDLE;
               end else begin
                  cmd.idx_clr = 1'b1;
                  state_in    = S_PRD;
               end
            end
         end
         S_PRD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = ifr_pkg::RA_PAY;
            state_in   = S_PWR;
         end
         S_PWR: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = ifr_pkg::OK_BYTE;
               cmd.idx_inc  = 1'b1;
               state_in     = sts.idx_last ? S_IDLE : S_PRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/idle_delimited_frame_receiver.sv
// Top level of the frame receiver: ifr_ctrl and ifr_datapath, types from ifr_pkg.
// Byte, line-idle and unknown items are handled in the idle state. A consume with no
// held frame shows its result the next cycle and is held off while an earlier result
// still waits. A held frame runs header reads (A0-A2), a check, then a read and a load
// per payload byte, plus any rsp_ready stall. Synchronous reset clears counts, the
// held flag and result valid flag and restores header 170 and limit 55, not the store.
module idle_delimited_frame_receiver #(
   parameter int BUFFER_DEPTH = ifr_pkg::BUFFER_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ifr_pkg::OP_W-1:0]          req_operation,
   input  logic [ifr_pkg::BYTE_W-1:0]        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ifr_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ifr_pkg::BYTE_W-1:0]        rsp_command,
   output logic [ifr_pkg::LEN_W-1:0]         rsp_payload_len,
   output logic                              rsp_has_byte,
   output logic [ifr_pkg::BYTE_W-1:0]        rsp_payload_byte,
   output logic                              rsp_last,
   input  logic                              csr_write_en,
   input  logic [ifr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ifr_pkg::CSR_W-1:0]         csr_wdata
);

   ifr_pkg::ifr_cmd_type    cmd;
   ifr_pkg::ifr_status_type sts;

   ifr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .sts           (sts),
      .cmd           (cmd)
   );

   ifr_datapath #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_rx_byte      (req_rx_byte),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_command      (rsp_command),
      .rsp_payload_len  (rsp_payload_len),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last)
   );

endmodule

// File: rtl/core/ifr_checker.sv
// Port-level checks of the frame receiver and the bind that attaches them.
// Depends on ifr_pkg and idle_delimited_frame_receiver.
module ifr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [ifr_pkg::OP_W-1:0]          req_operation,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [ifr_pkg::STATUS_W-1:0]      rsp_status,
   input logic                              rsp_has_byte,
   input logic [ifr_pkg::BYTE_W-1:0]        rsp_payload_byte,
   input logic                              rsp_last
);

   // A waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload_byte)
                                  && $stable(rsp_last))
      else $error("result dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // Byte and idle items never produce a result
   a_no_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid
      && (req_operation == ifr_pkg::OP_BYTE || req_operation == ifr_pkg::OP_IDLE)
      |=> !rsp_valid)
      else $error("result from a byte or idle item");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ifr_pkg::ST_VALID || !rsp_has_byte) |-> rsp_last)
      else $error("single-result consume not marked last");

   a_byte_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_byte |-> rsp_status == ifr_pkg::ST_VALID)
      else $error("payload byte on a non-valid frame");

endmodule

bind idle_delimited_frame_receiver ifr_checker u_ifr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_operation    (req_operation),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_has_byte     (rsp_has_byte),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_last         (rsp_last)
);
